@@ src/assert_macros.svh @@
// Assertion macros for the sorted table RTL.
// Depends on nothing; included by the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ src/stid_pkg.sv @@
// Package for the sorted table: depth, derived widths, codes and shared types.
// Depends on nothing.
package stid_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ src/stid_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module stid_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/stid_cmp.sv @@
// Shared signed compare unit of the sorted table walk.
// Depends on stid_pkg.
module stid_cmp (
  input  stid_pkg::word_t    a_i,
  input  stid_pkg::word_t    b_i,
  output stid_pkg::cmp_res_t res_o
);
  import stid_pkg::*;

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

@@ src/sorted_table_insert_delete.sv @@
// Sorted table of signed words: insert, delete of first match, read by index.
// Depends on stid_pkg, stid_ram and stid_cmp.
// An insert completes without a walk when full or empty, else shifts entries not below the value up one by one;
// a delete walks every entry (none when empty); a read checks the index, then reads the RAM.
// The result strobe is high in the cycle busy falls, so a new word may start then.
// Reset clears the count and control registers, not the entries; entries are undefined until written, no clearing pass.
module sorted_table_insert_delete (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               operation_i,
  input  stid_pkg::word_t          value_i,
  input  logic [3:0]               index_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output stid_pkg::word_t          read_value_o,
  output logic [4:0]               entry_count_o
);
  import stid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_EVAL,
    S_INS_PUT,
    S_DEL_EVAL,
    S_RD_WAIT
  } state_e;

  state_e          state_q, state_d;
  word_t           val_q, val_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] count_q, count_d;
  logic            found_q, found_d;
  logic            done_q, done_d;
  logic [1:0]      status_q, status_d;
  word_t           rdv_q, rdv_d;
  logic [4:0]      ecnt_q, ecnt_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  word_t           wdata;
  logic [IdxW-1:0] raddr;
  word_t           rdata;
  cmp_res_t        cmp;

  stid_ram #(
    .Width(32),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  stid_cmp u_cmp (
    .a_i  (rdata),
    .b_i  (val_q),
    .res_o(cmp)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_value_o  = rdv_q;
  assign entry_count_o = ecnt_q;

  always_comb begin
    state_d  = state_q;
    val_d    = val_q;
    k_d      = k_q;
    count_d  = count_q;
    found_d  = found_q;
    done_d   = 1'b0;
    status_d = status_q;
    rdv_d    = rdv_q;
    ecnt_d   = ecnt_q;
    we       = 1'b0;
    waddr    = IdxW'(k_q);
    wdata    = rdata;
    raddr    = IdxW'(k_q);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d    = value_i;
          status_d = ST_OK;
          rdv_d    = '0;
          ecnt_d   = 5'(count_q);
          case (operation_i)
            OP_INSERT: begin
              if (count_q == CntW'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = value_i;
                count_d = CntW'(1);
                ecnt_d  = 5'(CntW'(1));
                done_d  = 1'b1;
              end else begin
                k_d     = count_q;
                raddr   = IdxW'(count_q - CntW'(1));
                state_d = S_INS_EVAL;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                done_d   = 1'b1;
              end else begin
                k_d     = '0;
                found_d = 1'b0;
                raddr   = '0;
                state_d = S_DEL_EVAL;
              end
            end
            OP_READ: begin
              if (32'(index_i) >= 32'(count_q)) begin
                status_d = ST_BAD_INDEX;
                done_d   = 1'b1;
              end else begin
                raddr   = IdxW'(index_i);
                state_d = S_RD_WAIT;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_EVAL: begin
        we = 1'b1;
        if (cmp.lt) begin
          wdata   = val_q;
          count_d = count_q + CntW'(1);
          ecnt_d  = 5'(count_q + CntW'(1));
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          wdata = rdata;
          k_d   = k_q - CntW'(1);
          raddr = IdxW'(k_q - CntW'(2));
          if (k_q == CntW'(1)) begin
            state_d = S_INS_PUT;
          end
        end
      end
      S_INS_PUT: begin
        we      = 1'b1;
        wdata   = val_q;
        count_d = count_q + CntW'(1);
        ecnt_d  = 5'(count_q + CntW'(1));
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL_EVAL: begin
        if (found_q) begin
          we    = 1'b1;
          waddr = IdxW'(k_q - CntW'(1));
          wdata = rdata;
        end else if (cmp.eq) begin
          found_d = 1'b1;
        end
        if ((k_q + CntW'(1)) < count_q) begin
          k_d   = k_q + CntW'(1);
          raddr = IdxW'(k_q + CntW'(1));
        end else begin
          if (found_q || cmp.eq) begin
            count_d = count_q - CntW'(1);
            ecnt_d  = 5'(count_q - CntW'(1));
          end else begin
            status_d = ST_NOT_FOUND;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        rdv_d   = rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      val_q    <= '0;
      k_q      <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rdv_q    <= '0;
      ecnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      val_q    <= val_d;
      k_q      <= k_d;
      count_q  <= count_d;
      found_q  <= found_d;
      done_q   <= done_d;
      status_q <= status_d;
      rdv_q    <= rdv_d;
      ecnt_q   <= ecnt_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_done_when_idle, clk_i, rst_ni, done_q, state_q == S_IDLE)
  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, 32'(count_q) <= TABLE_DEPTH)
  `ASSERT_IMP(a_write_when_active, clk_i, rst_ni, we, busy_o || start_i)
  `ASSERT_NEXT(a_read_keeps_count, clk_i, rst_ni,
    start_i && !busy_o && operation_i == OP_READ, $stable(count_q))

endmodule
